[design/rsd_pkg.sv]
// Package for the radial spotlight dimmer: shared constants, register codes
// and the pipeline control struct. No dependencies.
`default_nettype none

package rsd_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 12;
    localparam int LUM_BITS_DEF   = 16;

    // Configuration registers
    localparam int CFG_BITS  = 14;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    // Distance: squared distance of 160 pixels and beyond saturates the dimming
    localparam int NEAR_LIMIT = 25600;
    localparam int RAD_BITS   = 15;

    // Square root pipeline (16 root bits, 8 fraction bits)
    localparam int ROOT_BITS       = 16;
    localparam int REM_BITS        = 18;
    localparam int PEND_BITS       = 32;
    localparam int SQRT_STAGES     = 4;
    localparam int STEPS_PER_STAGE = 4;

    // Scale: factor = 51200 - min(d_q8, 40960), divide by 51200 = 2^11 * 25
    localparam logic [ROOT_BITS-1:0] FULL_Q8 = 16'd51200;
    localparam logic [ROOT_BITS-1:0] KNEE_Q8 = 16'd40960;
    localparam int DIV_LOW_SHIFT = 11;
    localparam int DIV_ODD       = 25;

    // Control that travels with an item through the distance and root stages
    typedef struct packed {
        logic valid;
        logic far;
    } t_sq_ctl;

endpackage : rsd_pkg

`default_nettype wire

[design/rsd_dist.sv]
// Distance front end: absolute differences, squares, sum and near/far split.
// Three register stages. Depends on rsd_pkg.
`default_nettype none

module rsd_dist
    import rsd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [CFG_BITS-1:0]   i_center_x,
    input  wire logic [CFG_BITS-1:0]   i_center_y,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    input  wire logic [LUM_BITS-1:0]   i_lum,
    output t_sq_ctl                    o_ctl,
    output logic [RAD_BITS-1:0]        o_rad,
    output logic [COORD_BITS-1:0]      o_px,
    output logic [COORD_BITS-1:0]      o_py,
    output logic [LUM_BITS-1:0]        o_lum
);

    localparam int DIFF_BITS = ((CFG_BITS > COORD_BITS + 1) ? CFG_BITS : COORD_BITS + 1) + 1;
    localparam int ABS_BITS  = DIFF_BITS - 1;
    localparam int SQ_BITS   = 2 * ABS_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;

    // Stage 1: signed differences and their magnitudes
    logic [DIFF_BITS-1:0] w_dx, w_dy, w_dx_neg, w_dy_neg;
    logic [ABS_BITS-1:0]  n_ax, n_ay;

    assign w_dx = {{(DIFF_BITS-CFG_BITS){i_center_x[CFG_BITS-1]}}, i_center_x}
                - {{(DIFF_BITS-COORD_BITS){1'b0}}, i_pixel_x};
    assign w_dy = {{(DIFF_BITS-CFG_BITS){i_center_y[CFG_BITS-1]}}, i_center_y}
                - {{(DIFF_BITS-COORD_BITS){1'b0}}, i_pixel_y};
    assign w_dx_neg = ~w_dx + DIFF_BITS'(1);
    assign w_dy_neg = ~w_dy + DIFF_BITS'(1);
    assign n_ax = w_dx[DIFF_BITS-1] ? w_dx_neg[ABS_BITS-1:0] : w_dx[ABS_BITS-1:0];
    assign n_ay = w_dy[DIFF_BITS-1] ? w_dy_neg[ABS_BITS-1:0] : w_dy[ABS_BITS-1:0];

    logic                  r_v1;
    logic [ABS_BITS-1:0]   r_ax, r_ay;
    logic [COORD_BITS-1:0] r_px1, r_py1;
    logic [LUM_BITS-1:0]   r_lum1;

    // Stage 2: squares
    logic [SQ_BITS-1:0] n_sqx, n_sqy;
    assign n_sqx = r_ax * r_ax;
    assign n_sqy = r_ay * r_ay;

    logic                  r_v2;
    logic [SQ_BITS-1:0]    r_sqx, r_sqy;
    logic [COORD_BITS-1:0] r_px2, r_py2;
    logic [LUM_BITS-1:0]   r_lum2;

    // Stage 3: sum, far flag and near radicand
    logic [SUM_BITS-1:0] w_sum;
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    t_sq_ctl               r_ctl3;
    logic [RAD_BITS-1:0]   r_rad;
    logic [COORD_BITS-1:0] r_px3, r_py3;
    logic [LUM_BITS-1:0]   r_lum3;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_v1       <= i_valid;
            r_v2       <= r_v1;
            r_ctl3.valid <= r_v2;
            r_ctl3.far   <= (w_sum >= SUM_BITS'(NEAR_LIMIT));
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_px1  <= i_pixel_x;
            r_py1  <= i_pixel_y;
            r_lum1 <= i_lum;
            r_sqx  <= n_sqx;
            r_sqy  <= n_sqy;
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_lum2 <= r_lum1;
            r_rad  <= w_sum[RAD_BITS-1:0];
            r_px3  <= r_px2;
            r_py3  <= r_py2;
            r_lum3 <= r_lum2;
        end
    end

    assign o_ctl = r_ctl3;
    assign o_rad = r_rad;
    assign o_px  = r_px3;
    assign o_py  = r_py3;
    assign o_lum = r_lum3;

endmodule : rsd_dist

`default_nettype wire

[design/rsd_sqrt_stage.sv]
// One stage of the digit-by-digit square root: four root bits per stage.
// Carries the item's sideband along. Depends on rsd_pkg.
`default_nettype none

module rsd_sqrt_stage
    import rsd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_sq_ctl               i_ctl,
    input  wire logic [REM_BITS-1:0]   i_rem,
    input  wire logic [ROOT_BITS-1:0]  i_root,
    input  wire logic [PEND_BITS-1:0]  i_pend,
    input  wire logic [COORD_BITS-1:0] i_px,
    input  wire logic [COORD_BITS-1:0] i_py,
    input  wire logic [LUM_BITS-1:0]   i_lum,
    output t_sq_ctl                    o_ctl,
    output logic [REM_BITS-1:0]        o_rem,
    output logic [ROOT_BITS-1:0]       o_root,
    output logic [PEND_BITS-1:0]       o_pend,
    output logic [COORD_BITS-1:0]      o_px,
    output logic [COORD_BITS-1:0]      o_py,
    output logic [LUM_BITS-1:0]        o_lum
);

    logic [REM_BITS-1:0]  n_rem;
    logic [ROOT_BITS-1:0] n_root;
    logic [PEND_BITS-1:0] n_pend;

    // Restoring steps: bring down two radicand bits, try (root << 2) | 1
    always_comb begin
        logic [REM_BITS+1:0] v_trial;
        logic [REM_BITS+1:0] v_test;
        logic [REM_BITS+1:0] v_diff;
        n_rem  = i_rem;
        n_root = i_root;
        n_pend = i_pend;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            v_trial = {n_rem, n_pend[PEND_BITS-1 -: 2]};
            v_test  = {{(REM_BITS-ROOT_BITS){1'b0}}, n_root, 2'b01};
            v_diff  = v_trial - v_test;
            if (v_trial >= v_test) begin
                n_rem  = v_diff[REM_BITS-1:0];
                n_root = {n_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = v_trial[REM_BITS-1:0];
                n_root = {n_root[ROOT_BITS-2:0], 1'b0};
            end
            n_pend = {n_pend[PEND_BITS-3:0], 2'b00};
        end
    end

    t_sq_ctl               r_ctl;
    logic [REM_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0]  r_root;
    logic [PEND_BITS-1:0]  r_pend;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [LUM_BITS-1:0]   r_lum;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pend <= n_pend;
            r_px   <= i_px;
            r_py   <= i_py;
            r_lum  <= i_lum;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pend = r_pend;
    assign o_px   = r_px;
    assign o_py   = r_py;
    assign o_lum  = r_lum;

endmodule : rsd_sqrt_stage

`default_nettype wire

[design/rsd_scale.sv]
// Luminance scaling: factor multiply, divide by 51200 through a shift and a
// reciprocal multiply with one correction step. Three stages. Depends on rsd_pkg.
`default_nettype none

module rsd_scale
    import rsd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_sq_ctl               i_ctl,
    input  wire logic [ROOT_BITS-1:0]  i_root,
    input  wire logic [COORD_BITS-1:0] i_px,
    input  wire logic [COORD_BITS-1:0] i_py,
    input  wire logic [LUM_BITS-1:0]   i_lum,
    output logic                       o_valid,
    output logic [COORD_BITS-1:0]      o_px,
    output logic [COORD_BITS-1:0]      o_py,
    output logic [LUM_BITS-1:0]        o_lum
);

    localparam int PROD_BITS = LUM_BITS + ROOT_BITS;
    localparam int N_BITS    = PROD_BITS - DIV_LOW_SHIFT;
    localparam int Q_BITS    = LUM_BITS + 1;
    localparam logic [N_BITS-1:0] RECIP = N_BITS'((64'd1 << N_BITS) / DIV_ODD);

    // Stage A: lum * (51200 - min(d, 40960)), drop the 2^11 part of the divisor
    logic [ROOT_BITS-1:0] w_dist, w_factor;
    logic [PROD_BITS-1:0] w_prod;
    assign w_dist   = i_ctl.far ? KNEE_Q8 : i_root;
    assign w_factor = FULL_Q8 - w_dist;
    assign w_prod   = i_lum * w_factor;

    logic                  r_va;
    logic [N_BITS-1:0]     r_na;
    logic [COORD_BITS-1:0] r_pxa, r_pya;

    // Stage B: quotient estimate by 25, low by at most one
    logic [2*N_BITS-1:0] w_mq;
    assign w_mq = r_na * RECIP;

    logic                  r_vb;
    logic [N_BITS-1:0]     r_nb;
    logic [Q_BITS-1:0]     r_qb;
    logic [COORD_BITS-1:0] r_pxb, r_pyb;

    // Stage C: correct the estimate with one compare
    logic [N_BITS-1:0] w_back, w_rem;
    logic [Q_BITS-1:0] w_q;
    assign w_back = N_BITS'(r_qb) * N_BITS'(DIV_ODD);
    assign w_rem  = r_nb - w_back;
    assign w_q    = r_qb + Q_BITS'(w_rem >= N_BITS'(DIV_ODD));

    logic                  r_vc;
    logic [LUM_BITS-1:0]   r_lumc;
    logic [COORD_BITS-1:0] r_pxc, r_pyc;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_ctl.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na   <= w_prod[PROD_BITS-1:DIV_LOW_SHIFT];
            r_pxa  <= i_px;
            r_pya  <= i_py;
            r_nb   <= r_na;
            r_qb   <= w_mq[N_BITS+Q_BITS-1:N_BITS];
            r_pxb  <= r_pxa;
            r_pyb  <= r_pya;
            r_lumc <= w_q[LUM_BITS-1:0];
            r_pxc  <= r_pxb;
            r_pyc  <= r_pyb;
        end
    end

    assign o_valid = r_vc;
    assign o_px    = r_pxc;
    assign o_py    = r_pyc;
    assign o_lum   = r_lumc;

endmodule : rsd_scale

`default_nettype wire

[design/radial_spotlight_dimmer_unit.sv]
// Radial spotlight dimmer top level: configuration registers, pipeline
// control and assertions. Depends on rsd_pkg, rsd_dist, rsd_sqrt_stage, rsd_scale.
//
// Dims each pixel's luminance by 1 - min(distance/200, 0.8), where distance is
// the Euclidean distance from the pixel to the programmed center (center_x at
// byte address 0, center_y at 4, 14-bit two's complement), taken as a square
// root with 8 fraction bits; the result is truncated toward zero and the pixel
// coordinates pass through. The block accepts one item per clock while o_stall
// is low; it has 3 stages of differences, squares and sum, 4 square-root
// stages of 4 root bits each, and 3 stages of multiply and divide-by-constant.
// The whole pipeline moves as one: o_stall rises only while a finished result
// waits and i_stall is high, and then every stage holds.
// There is no clearing pass after reset. Program the center only while idle.
`default_nettype none

module radial_spotlight_dimmer_unit
    import rsd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Pixel input
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    input  wire logic [LUM_BITS-1:0]   i_lum_in,
    // Pixel output
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_BITS-1:0]      o_out_x,
    output logic [COORD_BITS-1:0]      o_out_y,
    output logic [LUM_BITS-1:0]        o_lum_out,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]       prdata,
    output logic                       pready
);

    // Configuration registers
    logic [CFG_BITS-1:0] r_center_x, r_center_y;
    logic                w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[ADDR_BITS-1])
                REG_CENTER_X: r_center_x <= pwdata[CFG_BITS-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back, sign extended
    always_comb begin
        unique case (paddr[ADDR_BITS-1])
            REG_CENTER_X: prdata = {{(DATA_BITS-CFG_BITS){r_center_x[CFG_BITS-1]}}, r_center_x};
            REG_CENTER_Y: prdata = {{(DATA_BITS-CFG_BITS){r_center_y[CFG_BITS-1]}}, r_center_y};
            default:      prdata = '0;
        endcase
    end

    // Pipeline advance: only a blocked result holds it
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // Stage boundary signals of the root pipeline
    t_sq_ctl               w_ctl  [0:SQRT_STAGES];
    logic [REM_BITS-1:0]   w_rem  [0:SQRT_STAGES];
    logic [ROOT_BITS-1:0]  w_root [0:SQRT_STAGES];
    logic [PEND_BITS-1:0]  w_pend [0:SQRT_STAGES];
    logic [COORD_BITS-1:0] w_px   [0:SQRT_STAGES];
    logic [COORD_BITS-1:0] w_py   [0:SQRT_STAGES];
    logic [LUM_BITS-1:0]   w_lum  [0:SQRT_STAGES];
    logic [RAD_BITS-1:0]   w_rad;

    rsd_dist #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_lum      (i_lum_in),
        .o_ctl      (w_ctl[0]),
        .o_rad      (w_rad),
        .o_px       (w_px[0]),
        .o_py       (w_py[0]),
        .o_lum      (w_lum[0])
    );

    // Radicand is the near squared distance scaled by 2^16
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_pend[0] = {1'b0, w_rad, {(PEND_BITS-RAD_BITS-1){1'b0}}};

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        rsd_sqrt_stage #(
            .COORD_BITS (COORD_BITS),
            .LUM_BITS   (LUM_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_pend  (w_pend[g]),
            .i_px    (w_px[g]),
            .i_py    (w_py[g]),
            .i_lum   (w_lum[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_pend  (w_pend[g+1]),
            .o_px    (w_px[g+1]),
            .o_py    (w_py[g+1]),
            .o_lum   (w_lum[g+1])
        );
    end

    rsd_scale #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[SQRT_STAGES]),
        .i_root  (w_root[SQRT_STAGES]),
        .i_px    (w_px[SQRT_STAGES]),
        .i_py    (w_py[SQRT_STAGES]),
        .i_lum   (w_lum[SQRT_STAGES]),
        .o_valid (o_valid),
        .o_px    (o_out_x),
        .o_py    (o_out_y),
        .o_lum   (o_lum_out)
    );

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !w_ctl[0].valid))
        else $error("pipeline not empty after reset");

    // A blocked result freezes the inner stages too
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(w_ctl[SQRT_STAGES]) && $stable(w_root[SQRT_STAGES])))
        else $error("inner stage moved during output stall");

    // Finished root: radicand fully consumed and remainder within 2*root
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[SQRT_STAGES].valid |->
            (w_pend[SQRT_STAGES] == '0 &&
             w_rem[SQRT_STAGES] <= {1'b0, w_root[SQRT_STAGES], 1'b0}))
        else $error("square root did not finish cleanly");

    // Near pixels stay below the knee distance
    a_near_below_knee: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[SQRT_STAGES].valid && !w_ctl[SQRT_STAGES].far) |->
            (w_root[SQRT_STAGES] < KNEE_Q8))
        else $error("near distance reached the knee");

endmodule : radial_spotlight_dimmer_unit

`default_nettype wire

[verif/tb_radial_spotlight_dimmer_unit.sv]
// Testbench for radial_spotlight_dimmer_unit: streams pixel items through the
// block and checks each result (coordinates and dimmed luminance) against an
// in-bench distance/scale calc. Depends on rsd_pkg and the design; reads no files.
`default_nettype none

module tb_radial_spotlight_dimmer_unit
    import rsd_pkg::*;
;

    localparam int CW = COORD_BITS_DEF;
    localparam int LW = LUM_BITS_DEF;
    // Scale is (FULL - min(d_q8, KNEE)) / FULL with d_q8 in 1/256 pixel
    localparam longint SCALE_FULL  = 51200;
    localparam longint SCALE_KNEE  = 40960;
    localparam int     QUIET_LIMIT = 4000;
    localparam int     PHASE_ITEMS = 192;
    localparam int     TAIL_CYCLES = 16;
    localparam int     PRINT_CAP   = 60;

    typedef struct packed {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [LW-1:0] lum;
    } t_pixel;

    // DUT signals, inputs known from time zero
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 i_valid   = 1'b0;
    logic                 o_stall;
    logic [CW-1:0]        i_pixel_x = '0;
    logic [CW-1:0]        i_pixel_y = '0;
    logic [LW-1:0]        i_lum_in  = '0;
    logic                 o_valid;
    logic                 i_stall   = 1'b0;
    logic [CW-1:0]        o_out_x;
    logic [CW-1:0]        o_out_y;
    logic [LW-1:0]        o_lum_out;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // Bench state
    t_pixel              pixel_q[$];
    t_pixel              dimmed_q[$];
    logic signed [CFG_BITS-1:0] center_x_q = '0;
    logic signed [CFG_BITS-1:0] center_y_q = '0;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  items_pushed  = 0;
    int                  results_seen  = 0;
    int                  quiet_cycles  = 0;
    int                  error_count   = 0;
    logic                in_took       = 1'b0;
    logic                out_took      = 1'b0;

    radial_spotlight_dimmer_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_lum_in  (i_lum_in),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_lum_out (o_lum_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Expected output for one pixel under the current center
    function automatic t_pixel dim_pixel(input t_pixel pix);
        longint dx, dy, dist_sq, trial, root;
        longint scale;
        t_pixel res;
        dx      = longint'(center_x_q) - longint'(pix.px);
        dy      = longint'(center_y_q) - longint'(pix.py);
        dist_sq = (dx * dx + dy * dy) << 16;
        // Build floor(sqrt) one bit at a time, top down
        root = 0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= dist_sq) begin
                root = trial;
            end
        end
        if (root > SCALE_KNEE) begin
            root = SCALE_KNEE;
        end
        scale   = SCALE_FULL - root;
        res.px  = pix.px;
        res.py  = pix.py;
        res.lum = LW'((longint'(pix.lum) * scale) / SCALE_FULL);
        return res;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Driver: next pixel goes out once the current one is taken
    always @(negedge i_clk) begin
        t_pixel nxt;
        if (i_rst_n && (!i_valid || in_took)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pixel_q.pop_front();
                i_valid   <= 1'b1;
                i_pixel_x <= nxt.px;
                i_pixel_y <= nxt.py;
                i_lum_in  <= nxt.lum;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: check results in order, predict on each accepted pixel
    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel taken;
        if (!i_rst_n) begin
            in_took      = 1'b0;
            out_took     = 1'b0;
            quiet_cycles = 0;
        end else begin
            if ($isunknown(o_valid)) begin
                report_error("o_valid unknown after reset");
            end
            in_took  = i_valid && !o_stall;
            out_took = o_valid && !i_stall;
            if (out_took) begin
                results_seen++;
                if (dimmed_q.size() == 0) begin
                    report_error($sformatf("unexpected result x=%0d y=%0d lum=%0d",
                                           o_out_x, o_out_y, o_lum_out));
                end else begin
                    want = dimmed_q.pop_front();
                    if (o_out_x !== want.px) begin
                        report_error($sformatf("out_x %0d, want %0d", o_out_x, want.px));
                    end
                    if (o_out_y !== want.py) begin
                        report_error($sformatf("out_y %0d, want %0d", o_out_y, want.py));
                    end
                    if (o_lum_out !== want.lum) begin
                        report_error($sformatf("lum_out %0d, want %0d (x=%0d y=%0d)",
                                               o_lum_out, want.lum, want.px, want.py));
                    end
                end
            end
            if (in_took) begin
                taken.px  = i_pixel_x;
                taken.py  = i_pixel_y;
                taken.lum = i_lum_in;
                dimmed_q.push_back(dim_pixel(taken));
            end
            quiet_cycles = (in_took || out_took) ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no handshake at all
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("simulation failed");
        $finish;
    end

    task automatic push_pixel(input int x, input int y, input int lum);
        t_pixel pix;
        pix.px  = CW'(x);
        pix.py  = CW'(y);
        pix.lum = LW'(lum);
        pixel_q.push_back(pix);
        items_pushed++;
    endtask

    task automatic wait_drain();
        while (results_seen < items_pushed) begin
            @(negedge i_clk);
        end
    endtask

    // APB write: setup then access; junk above the 14-bit field must be ignored
    task automatic write_center(input logic sel, input int val);
        logic [DATA_BITS-1:0] word;
        word           = $urandom();
        word[CFG_BITS-1:0] = val[CFG_BITS-1:0];
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_CENTER_X) begin
            center_x_q = val[CFG_BITS-1:0];
        end else begin
            center_y_q = val[CFG_BITS-1:0];
        end
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > (1 << CW) - 1) begin
            return (1 << CW) - 1;
        end
        return v;
    endfunction

    // Stimulus sequence
    initial begin
        int cx_set[8];
        int cy_set[8];
        int lum;
        int cx;
        int cy;
        cx_set = '{0, 8191, -8192, 2048, -1, 4095, 0, 0};
        cy_set = '{0, -8192, 8191, 2048, -1, 0, 0, 0};
        for (int k = 6; k < 8; k++) begin
            cx_set[k] = $signed(14'($urandom_range(16383)));
            cy_set[k] = $signed(14'($urandom_range(16383)));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, center still at its reset value of (0,0)
        push_pixel(0, 0, 65535);          // centre pixel keeps full luminance
        push_pixel(0, 0, 0);
        push_pixel(0, 0, 1);
        push_pixel(3, 4, 65535);          // distance 5
        push_pixel(160, 0, 65535);        // exactly at the knee
        push_pixel(159, 0, 65535);        // just inside
        push_pixel(0, 161, 65535);        // just beyond: lum/5
        push_pixel(96, 128, 12345);       // diagonal, distance exactly 160
        push_pixel(4095, 4095, 65535);    // far corner
        push_pixel(4095, 0, 65534);
        push_pixel(1, 1, 32768);
        push_pixel('haaa, 'h555, 'h5555);
        push_pixel('h555, 'haaa, 'haaaa);
        wait_drain();

        // Center at opposite extremes, then mid-image
        write_center(REG_CENTER_X, -8192);
        write_center(REG_CENTER_Y, 8191);
        push_pixel(0, 4095, 65535);
        push_pixel(4095, 0, 65535);
        wait_drain();
        write_center(REG_CENTER_X, 2048);
        write_center(REG_CENTER_Y, 2048);
        push_pixel(2048, 2048, 65535);
        push_pixel(2161, 2161, 65535);    // distance just under 160
        push_pixel(2048, 2248, 40000);    // distance 200, saturated
        push_pixel(2047, 2049, 7);
        push_pixel(1888, 2048, 65535);    // knee from the other side
        wait_drain();

        // Random phases, each with its own center and one of four idle/stall patterns
        for (int p = 0; p < 8; p++) begin
            wait_drain();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            write_center(REG_CENTER_X, cx_set[p]);
            write_center(REG_CENTER_Y, cy_set[p]);
            cx = cx_set[p];
            cy = cy_set[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(7))
                    0:       lum = 65535;
                    1:       lum = $urandom_range(3);
                    default: lum = $urandom_range(65535);
                endcase
                if ($urandom_range(1) == 0) begin
                    // Near the center, on both sides of the distance where the falloff saturates
                    push_pixel(clamp_coord(cx + int'($urandom_range(440)) - 220),
                               clamp_coord(cy + int'($urandom_range(440)) - 220), lum);
                end else begin
                    push_pixel($urandom_range(4095), $urandom_range(4095), lum);
                end
            end
        end

        // Drain, let any stray result show up, then judge
        wait_drain();
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (dimmed_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", dimmed_q.size()));
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule : tb_radial_spotlight_dimmer_unit

`default_nettype wire
